// File: rtl/core/cpa_pkg.sv
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared types, constants and controller/datapath bundles for the
// Coulomb potential accumulator core.
// ----------------------------------------------------------------------------
package cpa_pkg;

  localparam int MAX_NODES = 1024;
  localparam int NODE_AW   = $clog2(MAX_NODES);
  localparam int NODE_CW   = $clog2(MAX_NODES + 1);
  localparam int SLOTS     = 1024;
  localparam int SLOT_W    = 10;
  localparam int POS_W     = 32;
  localparam int ACC_W     = 64;
  localparam int D2_W      = 66;
  localparam int ROOT_W    = 34;
  localparam int SQ_REM_W  = 38;
  localparam int DIVD_W    = 80;
  localparam int DV_REM_W  = 35;
  localparam int CNT_W     = 7;
  localparam logic [31:0]      SCALE_RESET = 32'h0001_0000;
  localparam logic [CNT_W-1:0] SQRT_LAST   = CNT_W'(ROOT_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST    = CNT_W'(DIVD_W - 1);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_APPLY = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_LOAD, S_PREP, S_NRD, S_FETCH, S_SQX, S_SQY, S_SQZ,
    S_CHK, S_SQRT, S_DINIT, S_DIV, S_TERM, S_ACC, S_NEXT, S_RD, S_RDW
  } state_t;

  typedef struct packed {
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [POS_W-1:0]  z;
    logic [SLOT_W-1:0] target;
  } node_t;

  typedef struct packed {
    logic take;
    logic load_node;
    logic apply_start;
    logic node_rd;
    logic diff_cap;
    logic sq_x;
    logic sq_y;
    logic sq_z;
    logic flag_fault;
    logic sqrt_init;
    logic sqrt_step;
    logic div_init;
    logic div_step;
    logic term_cap;
    logic acc_wr;
    logic idx_adv;
    logic rd_slot;
    logic out_load;
    logic clr_start;
    logic clr_step;
  } cmd_t;

  typedef struct packed {
    logic req_fire;
    op_t  req_op;
    logic list_empty;
    logic d2_zero;
    logic sqrt_last;
    logic div_last;
    logic last_node;
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/core/cpa_if.sv
// ----------------------------------------------------------------------------
// cpa_if
// Request and response channels of the Coulomb potential accumulator.
// ----------------------------------------------------------------------------
interface cpa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [31:0] charge_value;
  logic [9:0]  slot_index;

  modport source (output valid, op, pos_x, pos_y, pos_z, charge_value, slot_index,
                  input ready);
  modport sink   (input valid, op, pos_x, pos_y, pos_z, charge_value, slot_index,
                  output ready);
endinterface

interface cpa_rsp_if;
  logic        valid;
  logic        ready;
  logic [9:0]  slot_index_out;
  logic [63:0] potential_sum;
  logic        saturated;
  logic        distance_fault;

  modport source (output valid, slot_index_out, potential_sum, saturated, distance_fault,
                  input ready);
  modport sink   (input valid, slot_index_out, potential_sum, saturated, distance_fault,
                  output ready);
endinterface

// File: rtl/core/cpa_ctrl.sv
// ----------------------------------------------------------------------------
// cpa_ctrl
// Sequencer: steps the datapath through load, per-node charge terms,
// reads and the accumulator clearing sweep.
// ----------------------------------------------------------------------------
module cpa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  cpa_pkg::sts_t sts,
  output cpa_pkg::cmd_t cmd
);

  cpa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cpa_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cpa_pkg::S_CLEAR: if (sts.clr_last) state_next = cpa_pkg::S_IDLE;
      cpa_pkg::S_IDLE: begin
        if (sts.req_fire) begin
          unique case (sts.req_op)
            cpa_pkg::OP_LOAD:  state_next = cpa_pkg::S_LOAD;
            cpa_pkg::OP_APPLY: state_next = cpa_pkg::S_PREP;
            cpa_pkg::OP_READ:  state_next = cpa_pkg::S_RD;
            cpa_pkg::OP_CLEAR: state_next = cpa_pkg::S_CLEAR;
            default:           state_next = cpa_pkg::S_IDLE;
          endcase
        end
      end
      cpa_pkg::S_LOAD:  state_next = cpa_pkg::S_IDLE;
      cpa_pkg::S_PREP:  state_next = sts.list_empty ? cpa_pkg::S_IDLE : cpa_pkg::S_NRD;
      cpa_pkg::S_NRD:   state_next = cpa_pkg::S_FETCH;
      cpa_pkg::S_FETCH: state_next = cpa_pkg::S_SQX;
      cpa_pkg::S_SQX:   state_next = cpa_pkg::S_SQY;
      cpa_pkg::S_SQY:   state_next = cpa_pkg::S_SQZ;
      cpa_pkg::S_SQZ:   state_next = cpa_pkg::S_CHK;
      cpa_pkg::S_CHK:   state_next = sts.d2_zero ? cpa_pkg::S_NEXT : cpa_pkg::S_SQRT;
      cpa_pkg::S_SQRT:  if (sts.sqrt_last) state_next = cpa_pkg::S_DINIT;
      cpa_pkg::S_DINIT: state_next = cpa_pkg::S_DIV;
      cpa_pkg::S_DIV:   if (sts.div_last) state_next = cpa_pkg::S_TERM;
      cpa_pkg::S_TERM:  state_next = cpa_pkg::S_ACC;
      cpa_pkg::S_ACC:   state_next = cpa_pkg::S_NEXT;
      cpa_pkg::S_NEXT:  state_next = sts.last_node ? cpa_pkg::S_IDLE : cpa_pkg::S_NRD;
      cpa_pkg::S_RD:    state_next = cpa_pkg::S_RDW;
      cpa_pkg::S_RDW:   if (sts.out_free) state_next = cpa_pkg::S_IDLE;
      default:          state_next = cpa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      cpa_pkg::S_CLEAR: cmd.clr_step = 1'b1;
      cpa_pkg::S_IDLE: begin
        cmd.take      = 1'b1;
        cmd.clr_start = sts.req_fire && (sts.req_op == cpa_pkg::OP_CLEAR);
      end
      cpa_pkg::S_LOAD:  cmd.load_node = 1'b1;
      cpa_pkg::S_PREP:  cmd.apply_start = 1'b1;
      cpa_pkg::S_NRD:   cmd.node_rd = 1'b1;
      cpa_pkg::S_FETCH: cmd.diff_cap = 1'b1;
      cpa_pkg::S_SQX:   cmd.sq_x = 1'b1;
      cpa_pkg::S_SQY:   cmd.sq_y = 1'b1;
      cpa_pkg::S_SQZ:   cmd.sq_z = 1'b1;
      cpa_pkg::S_CHK: begin
        cmd.flag_fault = sts.d2_zero;
        cmd.sqrt_init  = !sts.d2_zero;
      end
      cpa_pkg::S_SQRT:  cmd.sqrt_step = 1'b1;
      cpa_pkg::S_DINIT: cmd.div_init = 1'b1;
      cpa_pkg::S_DIV:   cmd.div_step = 1'b1;
      cpa_pkg::S_TERM:  cmd.term_cap = 1'b1;
      cpa_pkg::S_ACC:   cmd.acc_wr = 1'b1;
      cpa_pkg::S_NEXT:  cmd.idx_adv = !sts.last_node;
      cpa_pkg::S_RD:    cmd.rd_slot = 1'b1;
      cpa_pkg::S_RDW:   cmd.out_load = sts.out_free;
      default:          cmd = '0;
    endcase
  end

endmodule

// File: rtl/core/cpa_dp.sv
// ----------------------------------------------------------------------------
// cpa_dp
// Datapath: node list, accumulator memory, distance squares, bit-serial
// square root and divider, saturating accumulate and result register.
// ----------------------------------------------------------------------------
module cpa_dp (
  input  logic                clk,
  input  logic                rst,
  input  cpa_pkg::cmd_t       cmd,
  output cpa_pkg::sts_t       sts,
  cpa_req_if.sink             req,
  cpa_rsp_if.source           rsp,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata
);

  localparam int AW = cpa_pkg::NODE_AW;
  localparam int CW = cpa_pkg::NODE_CW;

  logic [31:0]                 scale;
  logic [31:0]                 rx, ry, rz, rq;
  logic [cpa_pkg::SLOT_W-1:0]  rslot;
  logic [CW-1:0]               node_count;
  logic [AW-1:0]               idx;
  logic                        fault;
  logic [cpa_pkg::SLOT_W-1:0]  clr_idx;

  cpa_pkg::node_t              node_mem [cpa_pkg::MAX_NODES];
  cpa_pkg::node_t              node_q;
  logic [cpa_pkg::ACC_W:0]     acc_mem  [cpa_pkg::SLOTS];
  logic [cpa_pkg::ACC_W:0]     acc_q;

  logic [63:0]                 pmag;
  logic                        qneg;
  logic [31:0]                 ax, ay, az;
  logic [cpa_pkg::D2_W-1:0]    d2;

  logic [67:0]                 sq_src;
  logic [cpa_pkg::SQ_REM_W-1:0] sq_rem;
  logic [cpa_pkg::ROOT_W-1:0]  sq_root;
  logic [cpa_pkg::DIVD_W-1:0]  dv_src;
  logic [cpa_pkg::DV_REM_W-1:0] dv_rem;
  logic [cpa_pkg::DIVD_W-1:0]  dv_q;
  logic [cpa_pkg::CNT_W-1:0]   cnt;

  logic [63:0]                 term;
  logic                        term_clip;

  logic                        out_valid;
  logic [cpa_pkg::SLOT_W-1:0]  out_slot;
  logic [63:0]                 out_sum;
  logic                        out_sat;
  logic                        out_fault;

  logic                        fire;
  logic                        full;
  logic [31:0]                 qmag;
  logic [32:0]                 dx, dy, dz;
  logic [31:0]                 sq_op;
  logic [63:0]                 sq_prod;
  logic [cpa_pkg::SQ_REM_W-1:0] sq_sh, sq_trial;
  logic [cpa_pkg::DV_REM_W-1:0] dv_sh, dv_den;
  logic [63:0]                 q_lim, q_cl;
  logic                        q_over;
  logic [63:0]                 acc_old, acc_sum, acc_res;
  logic                        acc_ovf;
  logic [cpa_pkg::SLOT_W-1:0]  acc_waddr;
  logic [cpa_pkg::ACC_W:0]     acc_wdata;
  logic                        acc_we;
  logic [cpa_pkg::SLOT_W-1:0]  acc_raddr;

  assign fire      = req.valid && cmd.take;
  assign req.ready = cmd.take;
  assign full      = (node_count == CW'(cpa_pkg::MAX_NODES));

  assign sts.req_fire   = fire;
  assign sts.req_op     = cpa_pkg::op_t'(req.op);
  assign sts.list_empty = (node_count == '0);
  assign sts.d2_zero    = (d2 == '0);
  assign sts.sqrt_last  = (cnt == cpa_pkg::SQRT_LAST);
  assign sts.div_last   = (cnt == cpa_pkg::DIV_LAST);
  assign sts.last_node  = ((CW'(idx) + CW'(1)) == node_count);
  assign sts.clr_last   = (clr_idx == cpa_pkg::SLOT_W'(cpa_pkg::SLOTS - 1));
  assign sts.out_free   = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= cpa_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      scale <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rx    <= req.pos_x;
      ry    <= req.pos_y;
      rz    <= req.pos_z;
      rq    <= req.charge_value;
      rslot <= req.slot_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= '0;
      fault      <= 1'b0;
      clr_idx    <= '0;
    end else begin
      if (cmd.clr_start) begin
        node_count <= '0;
        fault      <= 1'b0;
        clr_idx    <= '0;
      end else if (cmd.clr_step) begin
        clr_idx <= clr_idx + cpa_pkg::SLOT_W'(1);
      end
      if (cmd.load_node && !full) node_count <= node_count + CW'(1);
      if (cmd.flag_fault) fault <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_node && !full) begin
      node_mem[node_count[AW-1:0]] <= '{x: rx, y: ry, z: rz, target: rslot};
    end
    if (cmd.node_rd) node_q <= node_mem[idx];
  end

  assign qmag = rq[31] ? (32'd0 - rq) : rq;

  always_ff @(posedge clk) begin
    if (cmd.apply_start) begin
      idx  <= '0;
      pmag <= scale * qmag;
      qneg <= rq[31];
    end else if (cmd.idx_adv) begin
      idx <= idx + AW'(1);
    end
  end

  assign dx = {rx[31], rx} - {node_q.x[31], node_q.x};
  assign dy = {ry[31], ry} - {node_q.y[31], node_q.y};
  assign dz = {rz[31], rz} - {node_q.z[31], node_q.z};

  always_ff @(posedge clk) begin
    if (cmd.diff_cap) begin
      ax <= dx[32] ? 32'(33'd0 - dx) : dx[31:0];
      ay <= dy[32] ? 32'(33'd0 - dy) : dy[31:0];
      az <= dz[32] ? 32'(33'd0 - dz) : dz[31:0];
    end
  end

  assign sq_op   = cmd.sq_x ? ax : (cmd.sq_y ? ay : az);
  assign sq_prod = sq_op * sq_op;

  always_ff @(posedge clk) begin
    if (cmd.sq_x) begin
      d2 <= {2'b00, sq_prod};
    end else if (cmd.sq_y || cmd.sq_z) begin
      d2 <= d2 + {2'b00, sq_prod};
    end
  end

  assign sq_sh    = {sq_rem[cpa_pkg::SQ_REM_W-3:0], sq_src[67:66]};
  assign sq_trial = {2'b00, sq_root, 2'b01};
  assign dv_sh    = {dv_rem[cpa_pkg::DV_REM_W-2:0], dv_src[cpa_pkg::DIVD_W-1]};
  assign dv_den   = {1'b0, sq_root};

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      sq_src  <= {2'b00, d2};
      sq_rem  <= '0;
      sq_root <= '0;
      cnt     <= '0;
    end else if (cmd.sqrt_step) begin
      sq_src <= {sq_src[65:0], 2'b00};
      cnt    <= cnt + cpa_pkg::CNT_W'(1);
      if (sq_sh >= sq_trial) begin
        sq_rem  <= sq_sh - sq_trial;
        sq_root <= {sq_root[cpa_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem  <= sq_sh;
        sq_root <= {sq_root[cpa_pkg::ROOT_W-2:0], 1'b0};
      end
    end else if (cmd.div_init) begin
      cnt <= '0;
    end else if (cmd.div_step) begin
      cnt <= cnt + cpa_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dv_src <= {pmag, 16'h0000};
      dv_rem <= '0;
      dv_q   <= '0;
    end else if (cmd.div_step) begin
      dv_src <= {dv_src[cpa_pkg::DIVD_W-2:0], 1'b0};
      if (dv_sh >= dv_den) begin
        dv_rem <= dv_sh - dv_den;
        dv_q   <= {dv_q[cpa_pkg::DIVD_W-2:0], 1'b1};
      end else begin
        dv_rem <= dv_sh;
        dv_q   <= {dv_q[cpa_pkg::DIVD_W-2:0], 1'b0};
      end
    end
  end

  assign q_lim  = qneg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
  assign q_over = (|dv_q[cpa_pkg::DIVD_W-1:64]) || (dv_q[63:0] > q_lim);
  assign q_cl   = q_over ? q_lim : dv_q[63:0];

  always_ff @(posedge clk) begin
    if (cmd.term_cap) begin
      term      <= qneg ? (64'd0 - q_cl) : q_cl;
      term_clip <= q_over;
    end
  end

  assign acc_old = acc_q[63:0];
  assign acc_sum = acc_old + term;
  assign acc_ovf = (acc_old[63] == term[63]) && (acc_sum[63] != acc_old[63]);
  assign acc_res = acc_ovf ? (acc_old[63] ? 64'h8000_0000_0000_0000
                                          : 64'h7FFF_FFFF_FFFF_FFFF) : acc_sum;

  assign acc_we    = cmd.acc_wr || cmd.clr_step;
  assign acc_waddr = cmd.clr_step ? clr_idx : node_q.target;
  assign acc_wdata = cmd.clr_step ? '0 : {acc_q[64] | term_clip | acc_ovf, acc_res};
  assign acc_raddr = cmd.rd_slot ? rslot : node_q.target;

  always_ff @(posedge clk) begin
    if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
    if (cmd.rd_slot || cmd.div_init) acc_q <= acc_mem[acc_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_slot  <= rslot;
      out_sum   <= acc_q[63:0];
      out_sat   <= acc_q[64];
      out_fault <= fault;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.slot_index_out = out_slot;
  assign rsp.potential_sum  = out_sum;
  assign rsp.saturated      = out_sat;
  assign rsp.distance_fault = out_fault;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    node_count <= CW'(cpa_pkg::MAX_NODES))
    else $error("node count beyond list depth");

  a_root_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.div_init |-> (sq_root != '0))
    else $error("divide started with zero root");

  a_wr_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.acc_wr && cmd.clr_step))
    else $error("accumulate write during clear sweep");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !out_valid || rsp.ready)
    else $error("result register overwritten");

endmodule

// File: rtl/core/coulomb_potential_accumulator_core.sv
// ----------------------------------------------------------------------------
// coulomb_potential_accumulator_core
// Node list and per-slot Q32.32 potential accumulators fed by point charges.
//
//   channel  dir  handshake         request contents
//   req      in   valid/ready       op, pos_x/y/z, charge_value, slot_index
//   rsp      out  valid/ready       slot_index_out, potential_sum, flags
//   cfg      in   cfg_we            scale_factor (cfg_wdata)
//
// Load requests pass through S_LOAD and read requests through S_RD and
// S_RDW; a read waits in place while the result register is still full.
// Apply charge walks every loaded node in turn (a zero distance node skips
// the 34-step square root and 80-step divider, shared by all nodes).
// After reset and after each clear request all 1024 accumulator slots are
// swept clear, with req.ready low.
// ----------------------------------------------------------------------------
module coulomb_potential_accumulator_core (
  input  logic        clk,
  input  logic        rst,
  cpa_req_if.sink     req,
  cpa_rsp_if.source   rsp,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  cpa_pkg::cmd_t cmd;
  cpa_pkg::sts_t sts;

  cpa_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  cpa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Coulomb potential accumulator core. Loads node
// lists, applies point charges and reads accumulators back. A bit-exact
// Q32.32 potential predictor runs beside the core, and every read response is
// compared against it. Covers directed corner cases, random traffic under
// several idle patterns, and a long response stall.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [9:0]  slot;
    logic [63:0] sum;
    logic        sat;
    logic        fault;
  } readback_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  cpa_req_if req_ch();
  cpa_rsp_if rsp_ch();

  coulomb_potential_accumulator_core dut (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [31:0]        scale_q;
  logic [31:0]        nd_x [cpa_pkg::MAX_NODES];
  logic [31:0]        nd_y [cpa_pkg::MAX_NODES];
  logic [31:0]        nd_z [cpa_pkg::MAX_NODES];
  logic [9:0]         nd_slot [cpa_pkg::MAX_NODES];
  int                 node_total;
  logic signed [63:0] pot_acc [cpa_pkg::SLOTS];
  logic               pot_sat [cpa_pkg::SLOTS];
  logic               dist_fault;

  readback_t readback_q[$];
  int        errors;
  int        req_count;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        hold_left;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [33:0] root_of(logic [127:0] d2);
    logic [33:0]  r;
    logic [33:0]  c;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (34'd1 << b);
      if (128'(c) * 128'(c) <= d2) r = c;
    end
    return r;
  endfunction

  function automatic logic [32:0] abs_diff(logic [31:0] a, logic [31:0] b);
    logic signed [32:0] d;
    d = $signed({a[31], a}) - $signed({b[31], b});
    return d[32] ? 33'(-d) : 33'(d);
  endfunction

  function automatic void apply_potential(logic [31:0] px, logic [31:0] py,
                                          logic [31:0] pz, logic [31:0] q);
    logic               neg;
    logic [32:0]        qmag;
    logic [63:0]        pmag;
    logic [32:0]        ax, ay, az;
    logic [127:0]       d2, quo, lim;
    logic [33:0]        root_len;
    logic signed [63:0] term;
    logic signed [64:0] s;
    logic [9:0]         sl;
    bit                 clip;
    neg  = q[31];
    qmag = neg ? 33'd0 - {q[31], q} : {1'b0, q};
    pmag = 64'(scale_q) * 64'(qmag);
    for (int i = 0; i < node_total; i++) begin
      ax = abs_diff(px, nd_x[i]);
      ay = abs_diff(py, nd_y[i]);
      az = abs_diff(pz, nd_z[i]);
      d2 = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay) + 128'(az) * 128'(az);
      sl = nd_slot[i];
      if (d2 == 0) begin
        dist_fault = 1'b1;
        continue;
      end
      clip = 0;
      root_len = root_of(d2);
      quo  = {48'd0, pmag, 16'd0} / {94'd0, root_len};
      lim  = neg ? 128'h8000_0000_0000_0000 : 128'h7FFF_FFFF_FFFF_FFFF;
      if (quo > lim) begin
        clip = 1;
        quo  = lim;
      end
      term = neg ? -quo[63:0] : quo[63:0];
      s = {pot_acc[sl][63], pot_acc[sl]} + {term[63], term};
      if (s[64] != s[63]) begin
        clip = 1;
        pot_acc[sl] = s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end else begin
        pot_acc[sl] = s[63:0];
      end
      if (clip) pot_sat[sl] = 1'b1;
    end
  endfunction

  function automatic void predict_request(cpa_pkg::op_t op, logic [31:0] px,
                                          logic [31:0] py, logic [31:0] pz,
                                          logic [31:0] q, logic [9:0] sl);
    readback_t rb;
    case (op)
      cpa_pkg::OP_LOAD: begin
        if (node_total < cpa_pkg::MAX_NODES) begin
          nd_x[node_total] = px;
          nd_y[node_total] = py;
          nd_z[node_total] = pz;
          nd_slot[node_total] = sl;
          node_total++;
        end
      end
      cpa_pkg::OP_APPLY: apply_potential(px, py, pz, q);
      cpa_pkg::OP_READ: begin
        rb.slot  = sl;
        rb.sum   = pot_acc[sl];
        rb.sat   = pot_sat[sl];
        rb.fault = dist_fault;
        readback_q.push_back(rb);
      end
      default: begin
        node_total = 0;
        dist_fault = 1'b0;
        foreach (pot_acc[i]) begin
          pot_acc[i] = '0;
          pot_sat[i] = 1'b0;
        end
      end
    endcase
  endfunction

  task automatic send_request(cpa_pkg::op_t op, logic [31:0] px, logic [31:0] py,
                              logic [31:0] pz, logic [31:0] q, logic [9:0] sl);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.op           <= op;
    req_ch.pos_x        <= px;
    req_ch.pos_y        <= py;
    req_ch.pos_z        <= pz;
    req_ch.charge_value <= q;
    req_ch.slot_index   <= sl;
    do @(posedge clk); while (!req_ch.ready);
    predict_request(op, px, py, pz, q, sl);
    req_count++;
  endtask

  task automatic settle_block();
    send_request(cpa_pkg::OP_READ, '0, '0, '0, '0, 10'($urandom));
    req_ch.valid <= 1'b0;
    while (readback_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_scale(logic [31:0] v);
    settle_block();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    scale_q = v;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (readback_q.size() == 0) begin
          report_mismatch("unexpected response", rsp_ch.potential_sum, '0);
        end else begin
          readback_t rb;
          rb = readback_q.pop_front();
          if (rsp_ch.slot_index_out !== rb.slot)
            report_mismatch("slot", 64'(rsp_ch.slot_index_out), 64'(rb.slot));
          if (rsp_ch.potential_sum !== rb.sum)
            report_mismatch("potential", rsp_ch.potential_sum, rb.sum);
          if (rsp_ch.saturated !== rb.sat)
            report_mismatch("saturated", 64'(rsp_ch.saturated), 64'(rb.sat));
          if (rsp_ch.distance_fault !== rb.fault)
            report_mismatch("fault", 64'(rsp_ch.distance_fault), 64'(rb.fault));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    logic [31:0] r;
    r = $urandom;
    if ($urandom_range(3) == 0) return r;
    return {{12{r[19]}}, r[19:0]};
  endfunction

  function automatic logic [9:0] rand_slot();
    return ($urandom_range(9) < 7) ? 10'($urandom_range(7)) : 10'($urandom);
  endfunction

  task automatic test_reset_state();
    send_request(cpa_pkg::OP_READ, '0, '0, '0, '0, 10'd0);
    send_request(cpa_pkg::OP_READ, '0, '0, '0, '0, 10'd1023);
    send_request(cpa_pkg::OP_APPLY, 32'h0001_0000, '0, '0, 32'h0001_0000, 10'd0);
    send_request(cpa_pkg::OP_READ, '0, '0, '0, '0, 10'd0);
  endtask

  task automatic test_extremes();
    write_scale(32'hFFFF_FFFF);
    send_request(cpa_pkg::OP_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0, 10'd1023);
    send_request(cpa_pkg::OP_LOAD, '0, '0, '0, '0, 10'd5);
    send_request(cpa_pkg::OP_APPLY, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 10'd0);
    send_request(cpa_pkg::OP_APPLY, '0, '0, 32'h0000_0001, 32'h8000_0000, 10'd0);
    send_request(cpa_pkg::OP_APPLY, '0, '0, 32'h0000_0001, 32'h8000_0000, 10'd0);
    send_request(cpa_pkg::OP_READ, '0, '0, '0, '0, 10'd1023);
    send_request(cpa_pkg::OP_READ, '0, '0, '0, '0, 10'd5);
    send_request(cpa_pkg::OP_CLEAR, '0, '0, '0, '0, 10'd0);
    send_request(cpa_pkg::OP_LOAD, 32'hFFFF_FFFF, '0, '0, '0, 10'd2);
    send_request(cpa_pkg::OP_APPLY, '0, 32'h0000_0001, '0, 32'h7FFF_FFFF, 10'd0);
    send_request(cpa_pkg::OP_APPLY, '0, 32'h0000_0001, '0, 32'h7FFF_FFFF, 10'd0);
    send_request(cpa_pkg::OP_READ, '0, '0, '0, '0, 10'd2);
  endtask

  task automatic test_zero_distance();
    write_scale(32'h0000_0000);
    send_request(cpa_pkg::OP_LOAD, 32'h0003_0000, 32'h0004_0000, 32'h0005_0000, '0,
                 10'd7);
    send_request(cpa_pkg::OP_APPLY, 32'h0003_0000, 32'h0004_0000, 32'h0005_0000,
                 32'h0002_0000, 10'd0);
    send_request(cpa_pkg::OP_READ, '0, '0, '0, '0, 10'd7);
    send_request(cpa_pkg::OP_CLEAR, '0, '0, '0, '0, 10'd0);
    send_request(cpa_pkg::OP_READ, '0, '0, '0, '0, 10'd7);
  endtask

  task automatic test_long_list();
    write_scale(32'h0001_0000);
    for (int i = 0; i < 200; i++)
      send_request(cpa_pkg::OP_LOAD, 32'(i) << 16, '0, '0, '0, 10'd3);
    send_request(cpa_pkg::OP_LOAD, '0, '0, '0, '0, 10'd9);
    send_request(cpa_pkg::OP_APPLY, '0, 32'h0010_0000, '0, 32'h0001_0000, 10'd0);
    send_request(cpa_pkg::OP_READ, '0, '0, '0, '0, 10'd3);
    send_request(cpa_pkg::OP_READ, '0, '0, '0, '0, 10'd9);
    send_request(cpa_pkg::OP_CLEAR, '0, '0, '0, '0, 10'd0);
  endtask

  task automatic test_backpressure();
    settle_block();
    hold_left = 400;
    for (int i = 0; i < 8; i++)
      send_request(cpa_pkg::OP_READ, '0, '0, '0, '0, 10'(i));
  endtask

  task automatic test_random(int count);
    int stop_at;
    int pick;
    stop_at = req_count + count;
    while (req_count < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 3 || node_total >= 12) begin
        send_request(cpa_pkg::OP_CLEAR, $urandom, $urandom, $urandom, $urandom,
                     10'($urandom));
      end else if (pick < 35) begin
        repeat ($urandom_range(1, 4))
          send_request(cpa_pkg::OP_LOAD, rand_coord(), rand_coord(), rand_coord(),
                       $urandom, rand_slot());
      end else if (pick < 60) begin
        send_request(cpa_pkg::OP_APPLY, rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), 10'($urandom));
      end else begin
        send_request(cpa_pkg::OP_READ, $urandom, $urandom, $urandom, $urandom,
                     rand_slot());
      end
    end
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.op = cpa_pkg::OP_LOAD;
    req_ch.pos_x = '0;
    req_ch.pos_y = '0;
    req_ch.pos_z = '0;
    req_ch.charge_value = '0;
    req_ch.slot_index = '0;
    rsp_ch.ready = 1'b0;
    scale_q = cpa_pkg::SCALE_RESET;
    node_total = 0;
    dist_fault = 1'b0;
    foreach (pot_acc[i]) begin
      pot_acc[i] = '0;
      pot_sat[i] = 1'b0;
    end
    errors = 0;
    req_count = 0;
    hold_left = 0;
    send_idle_pct = 22;
    recv_idle_pct = 81;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_extremes();
    test_zero_distance();
    test_long_list();
    test_backpressure();
    write_scale($urandom);
    test_random(113);
    send_idle_pct = 81;
    recv_idle_pct = 22;
    write_scale(32'h0000_8000 + $urandom_range(32'h0002_0000));
    test_random(113);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_scale($urandom);
    test_random(113);

    req_ch.valid <= 1'b0;
    while (readback_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    #48_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/cpa_pkg.sv
rtl/core/cpa_if.sv
rtl/core/cpa_ctrl.sv
rtl/core/cpa_dp.sv
rtl/core/coulomb_potential_accumulator_core.sv
tb/tb_top.sv
